### rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, codes and helpers for the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	localparam int INT_BITS_DEF        = 31;
	localparam int FRAC_BITS_DEF       = 32;
	localparam int MAX_FRAC_DIGITS_DEF = 16;
	localparam int BASE_BITS_DEF       = 16;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int DIG_W      = 16;
	localparam int SYM_W      = 7;
	localparam int CNT_FRAC_W = 5;

	localparam int BASE_RESET  = 10;
	localparam int COUNT_RESET = 5;
	localparam int BASE_MIN    = 2;
	localparam int BASE_SYMBOL = 62;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_COUNT  = 1'd1;

	localparam logic [DIG_W-1:0] SYM_OFS_DIGIT = 16'd48;
	localparam logic [DIG_W-1:0] SYM_OFS_UPPER = 16'd55;
	localparam logic [DIG_W-1:0] SYM_OFS_LOWER = 16'd61;
	localparam logic [DIG_W-1:0] SYM_LAST_UPPER = 16'd35;
	localparam logic [DIG_W-1:0] SYM_LAST_LOWER = 16'd61;
	localparam logic [DIG_W-1:0] SYM_DECIMAL    = 16'd10;

	typedef enum logic [2:0] {
		KIND_MINUS = 3'd0,
		KIND_INT   = 3'd1,
		KIND_POINT = 3'd2,
		KIND_FRAC  = 3'd3,
		KIND_ERROR = 3'd4
	} rdc_kind_t;

	typedef struct packed {
		logic      load;
		logic      div_step;
		logic      store;
		logic      div_start;
		logic      rd;
		logic      mul_start;
		logic      mul_step;
		logic      frac_take;
		logic      emit;
		rdc_kind_t kind;
		logic      last;
	} rdc_cmd_t;

	typedef struct packed {
		logic base_bad;
		logic sign_item;
		logic fr_zero;
		logic q_zero;
		logic cnt_last;
		logic nd_zero;
		logic fcnt_zero;
		logic fcnt_one;
		logic out_free;
	} rdc_status_t;

	function automatic logic [SYM_W-1:0] symbol_of(input logic [DIG_W-1:0] d);
		logic [DIG_W-1:0] s;
		if (d < SYM_DECIMAL) begin
			s = d + SYM_OFS_DIGIT;
		end else if (d <= SYM_LAST_UPPER) begin
			s = d + SYM_OFS_UPPER;
		end else if (d <= SYM_LAST_LOWER) begin
			s = d + SYM_OFS_LOWER;
		end else begin
			s = '0;
		end
		return s[SYM_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/radix_digit_converter.sv
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a signed fixed-point number into a stream of digit beats in a
// configured base: minus, integer digits, point, fraction digits or error.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_ready   is_negative, integer_magnitude,
//                                             fraction_bits
//  out       source     out_valid / out_ready item_kind, digit_value,
//                                             symbol_code, last_item
//  cfg       sink       cfg_wr_en             cfg_index, cfg_wr_data
//
// One number is converted at a time. Each integer digit is found by the
// restoring divider (one quotient bit per cycle) and written to the digit
// store; the digits are then read back (S_IREAD) and emitted (S_IEMIT). Each
// fraction digit is formed by the shift-and-add multiplier. Output stalls
// hold the sequencer at the next emit. The digit store needs no clearing
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter
	import rdc_pkg::*;
#(
	parameter int INT_BITS        = INT_BITS_DEF,
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
	parameter int BASE_BITS       = BASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  is_negative,
	input  logic [INT_BITS-1:0]   integer_magnitude,
	input  logic [FRAC_BITS-1:0]  fraction_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            item_kind,
	output logic [DIG_W-1:0]      digit_value,
	output logic [SYM_W-1:0]      symbol_code,
	output logic                  last_item
);

	rdc_cmd_t    cmd;
	rdc_status_t status;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rdc_dpath #(
		.INT_BITS        (INT_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
		.BASE_BITS       (BASE_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wr_data       (cfg_wr_data),
		.is_negative       (is_negative),
		.integer_magnitude (integer_magnitude),
		.fraction_bits     (fraction_bits),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.item_kind         (item_kind),
		.digit_value       (digit_value),
		.symbol_code       (symbol_code),
		.last_item         (last_item)
	);

endmodule

`default_nettype wire

### rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer that steps the datapath through error, sign, division, digit readout
// and fraction multiplication for one number.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl
	import rdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rdc_status_t status,
	output rdc_cmd_t    cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_START = 11'b00000000010,
		S_ERR   = 11'b00000000100,
		S_SIGN  = 11'b00000001000,
		S_DIV   = 11'b00000010000,
		S_STORE = 11'b00000100000,
		S_IREAD = 11'b00001000000,
		S_IEMIT = 11'b00010000000,
		S_POINT = 11'b00100000000,
		S_MUL   = 11'b01000000000,
		S_FEMIT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (status.base_bad) begin
					state_d = S_ERR;
				end else if (status.sign_item) begin
					state_d = S_SIGN;
				end else begin
					state_d = S_DIV;
				end
			end
			S_ERR: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_ERROR;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SIGN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_MINUS;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.cnt_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				if (status.q_zero) begin
					state_d = S_IREAD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_IREAD: begin
				cmd.rd  = 1'b1;
				state_d = S_IEMIT;
			end
			S_IEMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_INT;
					cmd.last = status.nd_zero && status.fr_zero;
					if (!status.nd_zero) begin
						state_d = S_IREAD;
					end else if (status.fr_zero) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_POINT;
					end
				end
			end
			S_POINT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_POINT;
					cmd.last = status.fcnt_zero;
					if (status.fcnt_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.cnt_last) begin
					state_d = S_FEMIT;
				end
			end
			S_FEMIT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_FRAC;
					cmd.last      = status.fcnt_one;
					cmd.frac_take = 1'b1;
					if (status.fcnt_one) begin
						state_d = S_IDLE;
					end else begin
						cmd.mul_start = 1'b1;
						state_d       = S_MUL;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/rdc_dpath.sv
// ----------------------------------------------------------------------------
// rdc_dpath
// Configuration registers, bit-serial divider and multiplier, integer digit
// store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_dpath
	import rdc_pkg::*;
#(
	parameter int INT_BITS        = INT_BITS_DEF,
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF,
	parameter int BASE_BITS       = BASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  is_negative,
	input  logic [INT_BITS-1:0]   integer_magnitude,
	input  logic [FRAC_BITS-1:0]  fraction_bits,
	input  rdc_cmd_t              cmd,
	output rdc_status_t           status,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            item_kind,
	output logic [DIG_W-1:0]      digit_value,
	output logic [SYM_W-1:0]      symbol_code,
	output logic                  last_item
);

	localparam int PW    = FRAC_BITS + BASE_BITS;
	localparam int CMAX  = (INT_BITS > BASE_BITS) ? INT_BITS : BASE_BITS;
	localparam int CNT_W = $clog2(CMAX + 1);
	localparam int ND_W  = $clog2(INT_BITS + 1);
	localparam int AW    = $clog2(INT_BITS);
	localparam int FC_W  = $clog2(MAX_FRAC_DIGITS + 1);

	logic [BASE_BITS-1:0]  base_q;
	logic [CNT_FRAC_W-1:0] count_q;
	logic                  neg_q;
	logic [INT_BITS-1:0]   ip_q;
	logic [INT_BITS-1:0]   dvd_q;
	logic [BASE_BITS-1:0]  rem_q;
	logic [FRAC_BITS-1:0]  frac_q;
	logic [PW-1:0]         prod_q;
	logic [BASE_BITS-1:0]  msh_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ND_W-1:0]       nd_q;
	logic [FC_W-1:0]       fcnt_q;
	logic [DIG_W-1:0]      store_q [INT_BITS];
	logic [DIG_W-1:0]      rdata_q;
	logic                  out_valid_q;
	rdc_kind_t             kind_q;
	logic [DIG_W-1:0]      digit_q;
	logic [SYM_W-1:0]      sym_q;
	logic                  last_q;

	logic [BASE_BITS:0]   trial;
	logic [BASE_BITS:0]   diff;
	logic                 take;
	logic [BASE_BITS-1:0] rem_next;
	logic [PW-1:0]        addend;
	logic [ND_W-1:0]      nd_dec;
	logic [DIG_W-1:0]     emit_digit;
	logic                 sym_mode;

	assign trial    = {rem_q, dvd_q[INT_BITS-1]};
	assign diff     = trial - {1'b0, base_q};
	assign take     = trial >= {1'b0, base_q};
	assign rem_next = take ? diff[BASE_BITS-1:0] : trial[BASE_BITS-1:0];
	assign addend   = msh_q[BASE_BITS-1] ? PW'(frac_q) : '0;
	assign nd_dec   = nd_q - ND_W'(1);
	assign sym_mode = base_q < BASE_BITS'(BASE_SYMBOL);

	always_comb begin
		case (cmd.kind)
			KIND_INT:  emit_digit = rdata_q;
			KIND_FRAC: emit_digit = DIG_W'(prod_q[PW-1:FRAC_BITS]);
			default:   emit_digit = '0;
		endcase
	end

	assign status.base_bad  = base_q < BASE_BITS'(BASE_MIN);
	assign status.sign_item = neg_q && ((ip_q != '0) || (frac_q != '0));
	assign status.fr_zero   = frac_q == '0;
	assign status.q_zero    = dvd_q == '0;
	assign status.cnt_last  = cnt_q == CNT_W'(1);
	assign status.nd_zero   = nd_q == '0;
	assign status.fcnt_zero = fcnt_q == '0;
	assign status.fcnt_one  = fcnt_q == FC_W'(1);
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_BITS'(BASE_RESET);
			count_q     <= CNT_FRAC_W'(COUNT_RESET);
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			nd_q        <= '0;
			fcnt_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_TARGET_BASE: base_q  <= BASE_BITS'(cfg_wr_data);
					REG_FRAC_COUNT:  count_q <= cfg_wr_data[CNT_FRAC_W-1:0];
					default:         base_q  <= base_q;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load || cmd.div_start) begin
				cnt_q <= CNT_W'(INT_BITS);
			end else if (cmd.mul_start) begin
				cnt_q <= CNT_W'(BASE_BITS);
			end else if (cmd.div_step || cmd.mul_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.load) begin
				nd_q <= '0;
			end else if (cmd.store) begin
				nd_q <= nd_q + ND_W'(1);
			end else if (cmd.rd) begin
				nd_q <= nd_dec;
			end
			if (cmd.load) begin
				if (32'(count_q) > MAX_FRAC_DIGITS) begin
					fcnt_q <= FC_W'(MAX_FRAC_DIGITS);
				end else begin
					fcnt_q <= FC_W'(count_q);
				end
			end else if (cmd.frac_take) begin
				fcnt_q <= fcnt_q - FC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= is_negative;
			ip_q   <= integer_magnitude;
			dvd_q  <= integer_magnitude;
			rem_q  <= '0;
			frac_q <= fraction_bits;
		end else begin
			if (cmd.div_step) begin
				dvd_q <= {dvd_q[INT_BITS-2:0], take};
				rem_q <= rem_next;
			end else if (cmd.div_start) begin
				rem_q <= '0;
			end
			if (cmd.frac_take) begin
				frac_q <= prod_q[FRAC_BITS-1:0];
			end
		end
		if (cmd.mul_start) begin
			prod_q <= '0;
			msh_q  <= base_q;
		end else if (cmd.mul_step) begin
			prod_q <= {prod_q[PW-2:0], 1'b0} + addend;
			msh_q  <= {msh_q[BASE_BITS-2:0], 1'b0};
		end
		if (cmd.emit) begin
			kind_q  <= cmd.kind;
			digit_q <= emit_digit;
			last_q  <= cmd.last;
			if (((cmd.kind == KIND_INT) || (cmd.kind == KIND_FRAC)) && sym_mode) begin
				sym_q <= symbol_of(emit_digit);
			end else begin
				sym_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[nd_q[AW-1:0]] <= DIG_W'(rem_q);
		end
		if (cmd.rd) begin
			rdata_q <= store_q[nd_dec[AW-1:0]];
		end
	end

	assign out_valid   = out_valid_q;
	assign item_kind   = kind_q;
	assign digit_value = digit_q;
	assign symbol_code = sym_q;
	assign last_item   = last_q;

endmodule

`default_nettype wire

### rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_checker
	import rdc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [2:0]            item_kind,
	input logic [DIG_W-1:0]      digit_value,
	input logic [SYM_W-1:0]      symbol_code,
	input logic                  last_item
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind)
			&& $stable(digit_value) && $stable(symbol_code) && $stable(last_item))
		else $error("stalled result beat changed");

	// Only one number is in flight.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a number is in flight");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_ERROR) |-> last_item)
		else $error("error beat not marked last");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_MINUS) |-> !last_item)
		else $error("minus beat marked last");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((item_kind == KIND_MINUS) || (item_kind == KIND_POINT)
			|| (item_kind == KIND_ERROR)) |-> (digit_value == '0) && (symbol_code == '0))
		else $error("marker beat carries a digit");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

`default_nettype wire
